@@ rtl/core/bft_pkg.sv @@
// ----------------------------------------------------------------------------
// bft_pkg
// Shared constants, codes and types of the three-hash Bloom filter core.
// ----------------------------------------------------------------------------
package bft_pkg;

	// Bit store geometry
	localparam int unsigned FILTER_BITS = 4096;
	localparam int unsigned ADDR_W      = $clog2(FILTER_BITS);
	localparam int unsigned MOD_W       = $clog2(FILTER_BITS + 1);
	localparam int unsigned ROW_W       = 64;
	localparam int unsigned COL_W       = $clog2(ROW_W);
	localparam int unsigned ROWS        = (FILTER_BITS + ROW_W - 1) / ROW_W;
	localparam int unsigned ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;

	// Field widths
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned SIZE_W  = 13;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned HASH_W  = 64;
	localparam int unsigned CMP_W   = (SIZE_W > MOD_W) ? SIZE_W : MOD_W;

	// Hash lanes and their multipliers (lane 0 last in the literal)
	localparam int unsigned NUM_HASH = 3;
	localparam int unsigned LANE_W   = $clog2(NUM_HASH);
	localparam logic [NUM_HASH-1:0][7:0] MULT = {8'd41, 8'd37, 8'd31};

	// Modulo unit: dividend bits retired per cycle
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned MOD_CYCLES = HASH_W / DIGIT_W;
	localparam int unsigned MCNT_W     = $clog2(MOD_CYCLES);

	localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(4096);
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

	// Operation codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_QUERY = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Finished hashes handed to the modulo unit
	typedef struct packed {
		logic [FUNC_W-1:0]                  func;
		logic [NUM_HASH-1:0][HASH_W-1:0]    hash;
	} hash_job_t;

	// Bit positions handed to the bit store sequencer
	typedef struct packed {
		logic [FUNC_W-1:0]                  func;
		logic [NUM_HASH-1:0][ADDR_W-1:0]    idx;
	} bit_job_t;

	// Bit store port
	typedef struct packed {
		logic              we;
		logic              re;
		logic [ROW_AW-1:0] waddr;
		logic [ROW_AW-1:0] raddr;
		logic [ROW_W-1:0]  wdata;
	} ram_req_t;

endpackage

@@ rtl/core/bft_req_if.sv @@
// ----------------------------------------------------------------------------
// bft_req_if
// Request channel: one character of an item, or a clear, per transaction.
// ----------------------------------------------------------------------------
interface bft_req_if;
	logic                             valid;
	logic                             ready;
	logic [bft_pkg::FUNC_W-1:0]       func;
	logic signed [bft_pkg::CHAR_W-1:0] char_byte;
	logic                             byte_valid;
	logic                             last_byte;

	modport source (output valid, func, char_byte, byte_valid, last_byte, input ready);
	modport sink   (input valid, func, char_byte, byte_valid, last_byte, output ready);
endinterface

@@ rtl/core/bft_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bft_rsp_if
// Response channel: query answer and item count, one per transaction.
// ----------------------------------------------------------------------------
interface bft_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        maybe_present;
	logic [bft_pkg::COUNT_W-1:0] items_added;

	modport source (output valid, maybe_present, items_added, input ready);
	modport sink   (input valid, maybe_present, items_added, output ready);
endinterface

@@ rtl/core/bft_hash.sv @@
// ----------------------------------------------------------------------------
// bft_hash
// Front end: folds each accepted character into three running hashes and
// launches a job on the final character of an item or on a clear.
// ----------------------------------------------------------------------------
module bft_hash (
	input  logic                 clk,
	input  logic                 arst_n,
	bft_req_if.sink              req,
	input  logic                 job_busy,
	output logic                 launch,
	output bft_pkg::hash_job_t   job
);

	logic [bft_pkg::NUM_HASH-1:0][bft_pkg::HASH_W-1:0] hash_q;
	logic [bft_pkg::NUM_HASH-1:0][bft_pkg::HASH_W-1:0] folded;
	logic [bft_pkg::HASH_W-1:0] char_ext;
	logic is_item;
	logic is_clear;
	logic ends_job;
	logic accept;

	// Decode the operation
	assign is_item  = (req.func == bft_pkg::FUNC_ADD) || (req.func == bft_pkg::FUNC_QUERY);
	assign is_clear = (req.func == bft_pkg::FUNC_CLEAR);
	assign ends_job = is_clear || (is_item && req.last_byte);

	// Take plain characters every cycle; hold a job-ending one while a job runs
	assign req.ready = !ends_job || !job_busy;
	assign accept    = req.valid && req.ready;
	assign launch    = accept && ends_job;

	// Sign-extend the character and fold it into each lane
	assign char_ext = {{(bft_pkg::HASH_W - bft_pkg::CHAR_W){req.char_byte[bft_pkg::CHAR_W-1]}},
		req.char_byte};

	always_comb begin
		for (int k = 0; k < bft_pkg::NUM_HASH; k++) begin
			if (req.byte_valid) begin
				folded[k] = hash_q[k] * bft_pkg::HASH_W'(bft_pkg::MULT[k]) + char_ext;
			end else begin
				folded[k] = hash_q[k];
			end
		end
	end

	// Hand the finished hashes on; a clear carries zero hashes
	always_comb begin
		job.func = req.func;
		job.hash = is_clear ? '0 : folded;
	end

	// Advance the running hashes; restart them after an item or a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			if (ends_job) begin
				hash_q <= '0;
			end else if (is_item) begin
				hash_q <= folded;
			end
		end
	end

endmodule

@@ rtl/core/bft_mod.sv @@
// ----------------------------------------------------------------------------
// bft_mod
// Modulo unit: reduces three 64-bit hashes by the in-use filter size,
// restoring remainder, DIGIT_W dividend bits per cycle on all lanes at once.
// ----------------------------------------------------------------------------
module bft_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  bft_pkg::hash_job_t          start_job,
	input  logic [bft_pkg::MOD_W-1:0]   modulus,
	output logic                        busy,
	output logic                        done,
	output bft_pkg::bit_job_t           job
);

	logic [bft_pkg::NUM_HASH-1:0][bft_pkg::HASH_W-1:0] dvd_q;
	logic [bft_pkg::NUM_HASH-1:0][bft_pkg::MOD_W-1:0]  rem_q;
	logic [bft_pkg::NUM_HASH-1:0][bft_pkg::MOD_W-1:0]  rem_next;
	logic [bft_pkg::MOD_W-1:0]  mod_q;
	logic [bft_pkg::FUNC_W-1:0] func_q;
	logic [bft_pkg::MCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	// Retire DIGIT_W dividend bits per lane, MSB first
	always_comb begin
		logic [bft_pkg::MOD_W:0]   trial;
		logic [bft_pkg::MOD_W-1:0] r;
		trial = '0;
		r     = '0;
		for (int k = 0; k < bft_pkg::NUM_HASH; k++) begin
			r = rem_q[k];
			for (int j = 0; j < bft_pkg::DIGIT_W; j++) begin
				trial = {r, dvd_q[k][bft_pkg::HASH_W-1-j]};
				if (trial >= {1'b0, mod_q}) begin
					r = bft_pkg::MOD_W'(trial - {1'b0, mod_q});
				end else begin
					r = bft_pkg::MOD_W'(trial);
				end
			end
			rem_next[k] = r;
		end
	end

	// Sequence the division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + bft_pkg::MCNT_W'(1);
				if (cnt_q == bft_pkg::MCNT_W'(bft_pkg::MOD_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load or shift the dividend and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= start_job.hash;
			rem_q  <= '0;
			mod_q  <= modulus;
			func_q <= start_job.func;
		end else if (busy_q) begin
			for (int k = 0; k < bft_pkg::NUM_HASH; k++) begin
				dvd_q[k] <= dvd_q[k] << bft_pkg::DIGIT_W;
			end
			rem_q <= rem_next;
		end
	end

	// Remainders stay below the modulus, so they fit a bit address
	always_comb begin
		job.func = func_q;
		for (int k = 0; k < bft_pkg::NUM_HASH; k++) begin
			job.idx[k] = bft_pkg::ADDR_W'(rem_q[k]);
		end
	end

	assign busy = busy_q || done_q;
	assign done = done_q;

endmodule

@@ rtl/core/bft_bit_ram.sv @@
// ----------------------------------------------------------------------------
// bft_bit_ram
// Bit store: ROWS rows of ROW_W bits, one write and one registered read.
// ----------------------------------------------------------------------------
module bft_bit_ram (
	input  logic                         clk,
	input  bft_pkg::ram_req_t            ram_req,
	output logic [bft_pkg::ROW_W-1:0]    rdata
);

	logic [bft_pkg::ROW_W-1:0] mem [bft_pkg::ROWS];

	// Write port
	always_ff @(posedge clk) begin
		if (ram_req.we) begin
			mem[ram_req.waddr] <= ram_req.wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (ram_req.re) begin
			rdata <= mem[ram_req.raddr];
		end
	end

endmodule

@@ rtl/core/bft_access.sv @@
// ----------------------------------------------------------------------------
// bft_access
// Bit store sequencer: read-modify-write of the three bits of an add, three
// reads for a query, row flags for a clear; keeps the item count and the
// response register.
// ----------------------------------------------------------------------------
module bft_access (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  bft_pkg::bit_job_t         job,
	output logic                      busy,
	output bft_pkg::ram_req_t         ram_req,
	input  logic [bft_pkg::ROW_W-1:0] ram_rdata,
	bft_rsp_if.source                 rsp
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_MERGE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                                        state_q;
	logic [bft_pkg::LANE_W-1:0]                        lane_q;
	logic [bft_pkg::FUNC_W-1:0]                        func_q;
	logic [bft_pkg::NUM_HASH-1:0][bft_pkg::ADDR_W-1:0] idx_q;
	logic                                              hit_q;
	logic                                              rv_q;
	logic [bft_pkg::ROWS-1:0]                          row_valid_q;
	logic [bft_pkg::COUNT_W-1:0]                       count_q;
	logic [bft_pkg::COUNT_W-1:0]                       count_next;
	logic                                              rsp_valid_q;
	logic                                              rsp_hit_q;
	logic [bft_pkg::COUNT_W-1:0]                       rsp_count_q;

	logic [bft_pkg::ADDR_W-1:0] cur_idx;
	logic [bft_pkg::ROW_AW-1:0] cur_row;
	logic [bft_pkg::COL_W-1:0]  cur_col;
	logic [bft_pkg::ROW_W-1:0]  row_data;
	logic                       cur_bit;
	logic                       last_lane;
	logic                       load_rsp;

	// Split the current bit position into row and column
	assign cur_idx   = idx_q[lane_q];
	assign cur_row   = bft_pkg::ROW_AW'(cur_idx >> bft_pkg::COL_W);
	assign cur_col   = bft_pkg::COL_W'(cur_idx);
	assign row_data  = rv_q ? ram_rdata : '0;
	assign cur_bit   = row_data[cur_col];
	assign last_lane = (lane_q == bft_pkg::LANE_W'(bft_pkg::NUM_HASH - 1));
	assign load_rsp  = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Drive the bit store
	always_comb begin
		ram_req.re    = (state_q == ST_READ);
		ram_req.raddr = cur_row;
		ram_req.we    = (state_q == ST_MERGE) && (func_q == bft_pkg::FUNC_ADD);
		ram_req.waddr = cur_row;
		ram_req.wdata = row_data | (bft_pkg::ROW_W'(1) << cur_col);
	end

	// Saturating count after an add
	always_comb begin
		count_next = count_q;
		if ((func_q == bft_pkg::FUNC_ADD) && (count_q != bft_pkg::COUNT_MAX)) begin
			count_next = count_q + bft_pkg::COUNT_W'(1);
		end
	end

	// Control: sequence, row flags, count, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lane_q      <= '0;
			row_valid_q <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						lane_q <= '0;
						if (job.func == bft_pkg::FUNC_CLEAR) begin
							row_valid_q <= '0;
							count_q     <= '0;
							state_q     <= ST_DONE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (func_q == bft_pkg::FUNC_ADD) begin
						row_valid_q[cur_row] <= 1'b1;
					end
					if (last_lane) begin
						state_q <= ST_DONE;
					end else begin
						lane_q  <= lane_q + bft_pkg::LANE_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (load_rsp) begin
						count_q <= count_next;
						state_q <= ST_IDLE;
					end
				end
			endcase

			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload: job fields, read flags, query result, response
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			func_q <= job.func;
			idx_q  <= job.idx;
			hit_q  <= 1'b1;
		end
		if (state_q == ST_READ) begin
			rv_q <= row_valid_q[cur_row];
		end
		if (state_q == ST_MERGE) begin
			hit_q <= hit_q && cur_bit;
		end
		if (load_rsp) begin
			rsp_hit_q   <= (func_q == bft_pkg::FUNC_QUERY) && hit_q;
			rsp_count_q <= count_next;
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.maybe_present = rsp_hit_q;
	assign rsp.items_added   = rsp_count_q;

endmodule

@@ rtl/core/bloom_filter_three_hash_core.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_three_hash_core
// Flow: a final character or a clear starts a job that passes through the
//   modulo unit and the bit store sequencer to the response register.
// Throughput: one character per cycle; a job-ending transaction waits while
//   a job is still in the modulo unit or the bit store sequencer.
// Reset: hashes, count, row flags and response valid clear at once, no
//   clearing pass; filter_size returns to 4096.
// ----------------------------------------------------------------------------
module bloom_filter_three_hash_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bft_req_if.sink                       req,
	bft_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [bft_pkg::SIZE_W-1:0]    cfg_wdata
);

	logic [bft_pkg::SIZE_W-1:0] filter_size_q;
	logic [bft_pkg::MOD_W-1:0]  size_in_use;
	logic                       launch;
	bft_pkg::hash_job_t         hash_job;
	logic                       mod_busy;
	logic                       mod_done;
	bft_pkg::bit_job_t          bit_job;
	logic                       acc_busy;
	logic                       job_busy;
	bft_pkg::ram_req_t          ram_req;
	logic [bft_pkg::ROW_W-1:0]  ram_rdata;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_size_q <= bft_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			filter_size_q <= cfg_wdata;
		end
	end

	// Clamp the filter size to the store; a size of zero is used as one
	always_comb begin
		priority if (filter_size_q == '0) begin
			size_in_use = bft_pkg::MOD_W'(1);
		end else if (bft_pkg::CMP_W'(filter_size_q) > bft_pkg::CMP_W'(bft_pkg::FILTER_BITS)) begin
			size_in_use = bft_pkg::MOD_W'(bft_pkg::FILTER_BITS);
		end else begin
			size_in_use = bft_pkg::MOD_W'(filter_size_q);
		end
	end

	assign job_busy = mod_busy || acc_busy;

	bft_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.job_busy (job_busy),
		.launch   (launch),
		.job      (hash_job)
	);

	bft_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (launch),
		.start_job (hash_job),
		.modulus   (size_in_use),
		.busy      (mod_busy),
		.done      (mod_done),
		.job       (bit_job)
	);

	bft_bit_ram u_ram (
		.clk     (clk),
		.ram_req (ram_req),
		.rdata   (ram_rdata)
	);

	bft_access u_access (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_done),
		.job       (bit_job),
		.busy      (acc_busy),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.rsp       (rsp)
	);

endmodule

@@ rtl/core/bft_checker.sv @@
// ----------------------------------------------------------------------------
// bft_checker
// Port-level checks of the Bloom filter core, bound to the top level.
// ----------------------------------------------------------------------------
module bft_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [bft_pkg::FUNC_W-1:0]    req_func,
	input logic                          req_last_byte,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_maybe_present,
	input logic [bft_pkg::COUNT_W-1:0]   rsp_items_added
);

	logic ends_job;

	// A transaction that ends an item or clears the filter starts a job
	assign ends_job = req_valid && ((req_func == bft_pkg::FUNC_CLEAR) ||
		(((req_func == bft_pkg::FUNC_ADD) || (req_func == bft_pkg::FUNC_QUERY)) && req_last_byte));

	// Plain characters are never held back
	a_char_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !ends_job |-> req_ready)
		else $error("plain character transaction stalled");

	// Only one job in flight
	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		ends_job && req_ready |=> !(ends_job && req_ready))
		else $error("second job taken while one is running");

	// A hit needs at least one add since the last clear
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_maybe_present |-> rsp_items_added != '0)
		else $error("hit reported with an empty filter");

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_items_added) &&
			$stable(rsp_maybe_present))
		else $error("stalled response changed");

endmodule

bind bloom_filter_three_hash_core bft_checker u_bft_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_func          (req.func),
	.req_last_byte     (req.last_byte),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_maybe_present (rsp.maybe_present),
	.rsp_items_added   (rsp.items_added)
);

@@ dv/bloom_filter_three_hash_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_three_hash_core_test
// Self-checking bench for the three-hash Bloom filter core. Items are fed one
// character per transaction, with random gaps on the request side and random
// stalls on the response side. A local model of the hashes, the bit store and
// the item count predicts every response, and each response is checked field
// by field. Directed cases cover empty items, character extremes, mixed
// operations within an item, clears and filter size limits. A random phase
// then adds and queries words from a small pool under several filter sizes.
// ----------------------------------------------------------------------------
module bloom_filter_three_hash_core_test;

	localparam int unsigned CLK_HALF    = 10;
	localparam int unsigned RESET_LEN   = 11;
	localparam int unsigned SETTLE_LEN  = 30;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned ITEM_TARGET = 800;
	localparam int unsigned POOL_SIZE   = 24;
	localparam int unsigned WORD_MAX    = 12;
	localparam int unsigned REPORT_MAX  = 10;

	typedef struct packed {
		logic                        hit;
		logic [bft_pkg::COUNT_W-1:0] count;
	} answer_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [bft_pkg::SIZE_W-1:0] cfg_wdata;

	bft_req_if req ();
	bft_rsp_if rsp ();

	bloom_filter_three_hash_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Model of the filter
	logic [bft_pkg::HASH_W-1:0]  run_a, run_b, run_c;
	bit                          filter_map [bft_pkg::FILTER_BITS];
	logic [bft_pkg::COUNT_W-1:0] add_total;
	logic [bft_pkg::SIZE_W-1:0]  size_reg;
	answer_t                     pending_answers [$];

	// Word pool for adds and repeat queries
	logic [7:0] pool_chars [POOL_SIZE][WORD_MAX];
	int         pool_len   [POOL_SIZE];

	int  failures   = 0;
	int  items_sent = 0;
	bit  calm_src   = 1'b0;

	// Free-running clock
	always #(CLK_HALF) clk = ~clk;

	function automatic void reset_filter_model();
		filter_map = '{default: 1'b0};
		run_a      = '0;
		run_b      = '0;
		run_c      = '0;
		add_total  = '0;
		size_reg   = bft_pkg::SIZE_RESET;
	endfunction

	// Append an expected response
	function automatic void queue_answer(answer_t ans);
		pending_answers = {pending_answers, ans};
	endfunction

	// Advance the model by one accepted character or clear
	function automatic void filter_predict(bft_pkg::func_t f, logic [7:0] ch, logic bv,
		logic lb);
		logic [bft_pkg::HASH_W-1:0] sx, m;
		logic [bft_pkg::ADDR_W-1:0] ia, ib, ic;
		answer_t                    ans;
		if (f == bft_pkg::FUNC_CLEAR) begin
			filter_map = '{default: 1'b0};
			add_total  = '0;
			run_a      = '0;
			run_b      = '0;
			run_c      = '0;
			ans.hit    = 1'b0;
			ans.count  = '0;
			queue_answer(ans);
			return;
		end
		if (f == bft_pkg::FUNC_NOP)
			return;
		if (bv) begin
			sx    = {{(bft_pkg::HASH_W-8){ch[7]}}, ch};
			run_a = run_a * bft_pkg::HASH_W'(bft_pkg::MULT[0]) + sx;
			run_b = run_b * bft_pkg::HASH_W'(bft_pkg::MULT[1]) + sx;
			run_c = run_c * bft_pkg::HASH_W'(bft_pkg::MULT[2]) + sx;
		end
		if (!lb)
			return;
		// Clamp the in-use size, then reduce each hash
		if (size_reg == '0)
			m = bft_pkg::HASH_W'(1);
		else if (size_reg > bft_pkg::FILTER_BITS)
			m = bft_pkg::HASH_W'(bft_pkg::FILTER_BITS);
		else
			m = bft_pkg::HASH_W'(size_reg);
		ia    = bft_pkg::ADDR_W'(run_a % m);
		ib    = bft_pkg::ADDR_W'(run_b % m);
		ic    = bft_pkg::ADDR_W'(run_c % m);
		run_a = '0;
		run_b = '0;
		run_c = '0;
		if (f == bft_pkg::FUNC_ADD) begin
			filter_map[ia] = 1'b1;
			filter_map[ib] = 1'b1;
			filter_map[ic] = 1'b1;
			if (add_total != bft_pkg::COUNT_MAX)
				add_total = add_total + 1'b1;
			ans.hit = 1'b0;
		end else begin
			ans.hit = filter_map[ia] & filter_map[ib] & filter_map[ic];
		end
		ans.count = add_total;
		queue_answer(ans);
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic note_failure(string msg);
		failures++;
		if (failures <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Drive one character or clear and hold it until the transaction completes
	task automatic send_byte(bft_pkg::func_t f, logic [7:0] ch, logic bv, logic lb);
		int gap;
		gap = calm_src ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
		@(negedge clk);
		req.valid      <= 1'b1;
		req.func       <= f;
		req.char_byte  <= ch;
		req.byte_valid <= bv;
		req.last_byte  <= lb;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		filter_predict(f, ch, bv, lb);
		items_sent++;
	endtask

	// Drop valid, let all responses land and the core settle
	task automatic go_quiet();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_LEN) @(posedge clk);
	endtask

	task automatic write_size(logic [bft_pkg::SIZE_W-1:0] v);
		go_quiet();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		size_reg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic fill_word(int slot);
		int r, i;
		r = $urandom_range(0, 19);
		if (r == 0)
			pool_len[slot] = 0;
		else if (r < 17)
			pool_len[slot] = $urandom_range(1, 6);
		else
			pool_len[slot] = $urandom_range(7, WORD_MAX);
		for (i = 0; i < WORD_MAX; i++) pool_chars[slot][i] = 8'($urandom);
	endtask

	// Send a pool word; a ragged send mixes operations, skipped and ignored bytes
	task automatic send_word(bft_pkg::func_t f, int slot, bit ragged);
		int             i;
		bft_pkg::func_t mid;
		if (pool_len[slot] == 0) begin
			send_byte(f, 8'($urandom), 1'b0, 1'b1);
			return;
		end
		for (i = 0; i < pool_len[slot]; i++) begin
			mid = f;
			if (ragged && i != pool_len[slot] - 1) begin
				mid = $urandom_range(0, 1) ? bft_pkg::FUNC_ADD : bft_pkg::FUNC_QUERY;
				if ($urandom_range(0, 3) == 0)
					send_byte(mid, 8'($urandom), 1'b0, 1'b0);
				if ($urandom_range(0, 4) == 0)
					send_byte(bft_pkg::FUNC_NOP, 8'($urandom), 1'($urandom), 1'($urandom));
			end
			send_byte(mid, pool_chars[slot][i], 1'b1, i == pool_len[slot] - 1);
		end
	endtask

	task automatic test_empty_item();
		send_byte(bft_pkg::FUNC_QUERY, 8'h00, 1'b0, 1'b1);
		send_byte(bft_pkg::FUNC_ADD, 8'hA5, 1'b0, 1'b1);
		send_byte(bft_pkg::FUNC_QUERY, 8'h5A, 1'b0, 1'b1);
	endtask

	task automatic test_char_extremes();
		send_byte(bft_pkg::FUNC_ADD, 8'h80, 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_ADD, 8'h7F, 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_ADD, 8'h00, 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_ADD, 8'hFF, 1'b1, 1'b1);
		// Same item with a skipped byte in the middle
		send_byte(bft_pkg::FUNC_QUERY, 8'h80, 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_QUERY, 8'h33, 1'b0, 1'b0);
		send_byte(bft_pkg::FUNC_QUERY, 8'h7F, 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_QUERY, 8'h00, 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_QUERY, 8'hFF, 1'b1, 1'b1);
		send_byte(bft_pkg::FUNC_QUERY, 8'h80, 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_QUERY, 8'h7F, 1'b1, 1'b1);
	endtask

	task automatic test_mixed_funcs();
		send_byte(bft_pkg::FUNC_QUERY, "a", 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_NOP, 8'hC3, 1'b1, 1'b1);
		send_byte(bft_pkg::FUNC_ADD, "b", 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_ADD, "c", 1'b1, 1'b1);
		send_byte(bft_pkg::FUNC_ADD, "a", 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_ADD, "b", 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_QUERY, "c", 1'b1, 1'b1);
	endtask

	task automatic test_clear();
		send_byte(bft_pkg::FUNC_ADD, "x", 1'b1, 1'b0);
		send_byte(bft_pkg::FUNC_CLEAR, 8'($urandom), 1'b1, 1'b1);
		send_byte(bft_pkg::FUNC_QUERY, "y", 1'b1, 1'b1);
		send_byte(bft_pkg::FUNC_QUERY, 8'h80, 1'b0, 1'b1);
		send_byte(bft_pkg::FUNC_ADD, "y", 1'b1, 1'b1);
	endtask

	task automatic test_size_limits();
		write_size('0);
		send_byte(bft_pkg::FUNC_ADD, "q", 1'b1, 1'b1);
		send_byte(bft_pkg::FUNC_QUERY, "r", 1'b1, 1'b1);
		write_size('1);
		send_byte(bft_pkg::FUNC_QUERY, "q", 1'b1, 1'b1);
		send_byte(bft_pkg::FUNC_ADD, "q", 1'b1, 1'b1);
		write_size(bft_pkg::SIZE_W'(1));
		send_byte(bft_pkg::FUNC_QUERY, "z", 1'b1, 1'b1);
		write_size(bft_pkg::SIZE_RESET);
	endtask

	task automatic test_random_traffic();
		int r, slot, i, phase_items;
		phase_items = 0;
		for (i = 0; i < POOL_SIZE; i++) fill_word(i);
		while (items_sent < ITEM_TARGET) begin
			// Start a new phase with a fresh filter size
			if (phase_items >= 120) begin
				phase_items = 0;
				r = $urandom_range(0, 6);
				case (r)
					0: write_size(bft_pkg::SIZE_RESET);
					1: write_size('1);
					2: write_size('0);
					3: write_size(bft_pkg::SIZE_W'(1));
					4: write_size(bft_pkg::SIZE_W'($urandom_range(2, 64)));
					5: write_size(bft_pkg::SIZE_W'($urandom_range(4097, 8191)));
					default: write_size(bft_pkg::SIZE_W'($urandom_range(1, bft_pkg::FILTER_BITS)));
				endcase
				calm_src = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 1))
					send_byte(bft_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
			end
			phase_items = phase_items + 1;
			slot = $urandom_range(0, POOL_SIZE - 1);
			r    = $urandom_range(0, 99);
			if (r < 30) begin
				fill_word(slot);
				send_word(bft_pkg::FUNC_ADD, slot, 1'b0);
			end else if (r < 60) begin
				send_word(bft_pkg::FUNC_QUERY, slot, 1'b0);
			end else if (r < 72) begin
				fill_word(slot);
				send_word(bft_pkg::FUNC_QUERY, slot, 1'b0);
			end else if (r < 80) begin
				send_word(bft_pkg::FUNC_ADD, slot, 1'b0);
			end else if (r < 88) begin
				send_word($urandom_range(0, 1) ? bft_pkg::FUNC_ADD : bft_pkg::FUNC_QUERY,
					slot, 1'b1);
			end else if (r < 94) begin
				send_byte(bft_pkg::func_t'($urandom_range(0, 3)), 8'($urandom),
					1'($urandom), 1'($urandom));
			end else if (r < 97) begin
				// Abandon a partly hashed item with a clear
				for (i = 0; i + 1 < pool_len[slot]; i++)
					send_byte(bft_pkg::FUNC_ADD, pool_chars[slot][i], 1'b1, 1'b0);
				send_byte(bft_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				send_byte(bft_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
			end
		end
	endtask

	// Response side: alternate ready stretches and stalls
	initial begin : rsp_pacing
		int len;
		rsp.ready = 1'b0;
		forever begin
			len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 8);
			repeat (len) begin
				@(negedge clk);
				rsp.ready <= 1'b1;
			end
			len = pick_gap();
			repeat (len) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
			end
		end
	end

	// Check each response against the oldest expectation
	initial begin : answer_check
		answer_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (pending_answers.size() == 0) begin
					note_failure($sformatf("unexpected response hit=%0b count=%0d",
						rsp.maybe_present, rsp.items_added));
				end else begin
					want = pending_answers.pop_front();
					if (rsp.maybe_present !== want.hit || rsp.items_added !== want.count)
						note_failure($sformatf(
							"response mismatch: exp hit=%0b count=%0d, got hit=%0b count=%0d",
							want.hit, want.count, rsp.maybe_present, rsp.items_added));
				end
			end
		end
	end

	// Stop a run that makes no progress
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req.valid === 1'b1 && req.ready === 1'b1) ||
			    (rsp.valid === 1'b1 && rsp.ready === 1'b1) || cfg_we === 1'b1)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Test sequence
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		req.valid      = 1'b0;
		req.func       = bft_pkg::FUNC_NOP;
		req.char_byte  = '0;
		req.byte_valid = 1'b0;
		req.last_byte  = 1'b0;
		reset_filter_model();
		repeat (RESET_LEN) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_item();
		test_char_extremes();
		test_mixed_funcs();
		test_clear();
		test_size_limits();
		test_random_traffic();

		go_quiet();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/bft_pkg.sv
rtl/core/bft_req_if.sv
rtl/core/bft_rsp_if.sv
rtl/core/bft_hash.sv
rtl/core/bft_mod.sv
rtl/core/bft_bit_ram.sv
rtl/core/bft_access.sv
rtl/core/bloom_filter_three_hash_core.sv
rtl/core/bft_checker.sv
dv/bloom_filter_three_hash_core_test.sv
